### hdl/ccq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccq_pkg: shared types for the circle coverage query unit
// Request codes, result kinds, table entry layout and the scan token.
// ----------------------------------------------------------------------------
package ccq_pkg;

    // Request codes; code 3 is dropped by the decoder default arm.
    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_LARGEST = 2'd2
    } t_action;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_HIT     = 2'd0,
        KIND_NONE    = 2'd1,
        KIND_LARGEST = 2'd2
    } t_kind;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } t_state;

    // One table entry as stored in memory.
    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [23:0]        rad;
        logic [15:0]        cap;
    } t_entry;

    // Token that walks the scan pipeline with each memory read.
    typedef struct packed {
        logic       vld;
        logic [2:0] idx;
        logic       fin;
        logic       skip;
    } t_token;

endpackage

### hdl/ccq_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccq_table: circle table memory
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module ccq_table #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  ccq_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output ccq_pkg::t_entry o_rdata
);
    import ccq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ccq_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccq_scan: distance test, largest search and result output
// Three pipeline stages behind the memory read, a held entry that delays
// each hit by one so the final one can carry last, and the output register.
// ----------------------------------------------------------------------------
module ccq_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ccq_pkg::t_token    i_token,
    input  ccq_pkg::t_entry    i_rdata,
    input  logic signed [15:0] i_px,
    input  logic signed [15:0] i_py,
    input  logic               i_query,
    output logic               o_adv,
    output logic               o_done,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ccq_pkg::t_kind     o_kind,
    output logic [2:0]         o_index,
    output logic signed [15:0] o_center_x,
    output logic signed [15:0] o_center_y,
    output logic [23:0]        o_radius_out,
    output logic [15:0]        o_capacity_out,
    output logic               o_last
);
    import ccq_pkg::*;

    t_token r_t1, r_t2, r_t3;
    t_entry r_e2, r_e3;
    logic [15:0] r_ax, r_ay;
    logic [31:0] r_sqx, r_sqy;
    logic [47:0] r_sqr;

    t_entry r_held;
    logic [2:0] r_held_idx;
    logic r_held_vld, n_held_vld;
    logic r_flush, n_flush;
    logic r_out_vld, n_out_vld;

    logic signed [16:0] dx, dy;
    logic [15:0] ax, ay;
    logic [32:0] dsum;
    logic hit, out_free, push_hit, take, better;

    // Stage 1 -> 2: absolute distances.
    assign dx = {i_px[15], i_px} - {i_rdata.cx[15], i_rdata.cx};
    assign dy = {i_py[15], i_py} - {i_rdata.cy[15], i_rdata.cy};
    assign ax = dx[16] ? 16'(-dx) : dx[15:0];
    assign ay = dy[16] ? 16'(-dy) : dy[15:0];

    // Stage 3: exact disk test and largest compare.
    assign dsum     = 33'(r_sqx) + 33'(r_sqy);
    assign hit      = r_t3.vld && !r_t3.skip && ({dsum, 16'h0} <= {1'b0, r_sqr});
    assign better   = (r_t3.idx == 3'd0) || (r_e3.rad > r_held.rad);
    assign out_free = !r_out_vld || !i_out_stall;
    assign push_hit = i_query && hit && r_held_vld;
    assign o_adv    = !(push_hit && !out_free);
    assign take     = o_adv && r_t3.vld && (i_query ? hit : better);
    assign o_done   = r_flush && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
        end else if (o_adv) begin
            r_t1 <= i_token;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_e2  <= i_rdata;
            r_ax  <= ax;
            r_ay  <= ay;
            r_e3  <= r_e2;
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
            r_sqr <= r_e2.rad * r_e2.rad;
        end
    end

    always_comb begin
        n_held_vld = r_held_vld;
        n_flush    = r_flush;
        n_out_vld  = r_out_vld && i_out_stall;
        if (take) begin
            n_held_vld = 1'b1;
        end
        if (o_adv && r_t3.vld && r_t3.fin) begin
            n_flush = 1'b1;
        end
        if (o_adv && push_hit) begin
            n_out_vld = 1'b1;
        end
        if (o_done) begin
            n_flush    = 1'b0;
            n_held_vld = 1'b0;
            n_out_vld  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vld <= 1'b0;
            r_flush    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_held_vld <= n_held_vld;
            r_flush    <= n_flush;
            r_out_vld  <= n_out_vld;
        end
    end

    // Held entry: latest hit for a query, best so far for a largest search.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_held     <= r_e3;
            r_held_idx <= r_t3.idx;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (o_adv && push_hit) begin
            o_kind         <= KIND_HIT;
            o_index        <= r_held_idx;
            o_center_x     <= r_held.cx;
            o_center_y     <= r_held.cy;
            o_radius_out   <= r_held.rad;
            o_capacity_out <= r_held.cap;
            o_last         <= 1'b0;
        end else if (o_done) begin
            o_last <= 1'b1;
            if (i_query && !r_held_vld) begin
                o_kind         <= KIND_NONE;
                o_index        <= '0;
                o_center_x     <= '0;
                o_center_y     <= '0;
                o_radius_out   <= '0;
                o_capacity_out <= '0;
            end else begin
                o_kind         <= i_query ? KIND_HIT : KIND_LARGEST;
                o_index        <= r_held_idx;
                o_center_x     <= r_held.cx;
                o_center_y     <= r_held.cy;
                o_radius_out   <= r_held.rad;
                o_capacity_out <= r_held.cap;
            end
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

### hdl/circle_coverage_query_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_coverage_query_unit: point-in-circle queries over a circle table
// Loads circles into a small memory, answers coverage and largest-radius
// requests by scanning the table one entry per cycle while the scan advances.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_stall): one request per handshake.
//   A load writes one table entry in the accept cycle and gives no result;
//   code 3 is dropped. A query returns one result per covering circle, in
//   table order, or one "none" result; a largest request returns one result.
//   o_last marks the final result of each request.
//   Result channel (o_out_valid / i_out_stall): results sit in an output
//   register and hold while i_out_stall is high; the scan pipeline freezes
//   only when a hit must be pushed while that register is still full.
//   Sequence: a request scanning N entries (N at least 1) issues N reads, then
//   two pipeline stages, the flush register and the output load; the last
//   result waits out any output stall, and the next request is taken once
//   the sequencer is back in idle. Loads leave the sequencer idle, so they
//   do not stall the request channel.
//   o_in_stall is high from the accept of a query or largest request until
//   its last result has entered the output register.
//   Config (i_cfg_valid / o_cfg_ready): writes circles_in_use; write it only
//   while the block is idle.
//   Reset clears control state and circles_in_use; table contents are
//   undefined until loaded, and no clearing pass runs.
// ----------------------------------------------------------------------------
module circle_coverage_query_unit #(
    parameter int MAX_CIRCLES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [2:0]         i_slot,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [23:0]        i_radius,
    input  logic [15:0]        i_capacity,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ccq_pkg::t_kind     o_kind,
    output logic [2:0]         o_index,
    output logic signed [15:0] o_center_x,
    output logic signed [15:0] o_center_y,
    output logic [23:0]        o_radius_out,
    output logic [15:0]        o_capacity_out,
    output logic               o_last,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data
);
    import ccq_pkg::*;

    localparam int AW    = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int LIMIT = (MAX_CIRCLES < 8) ? MAX_CIRCLES : 8;

    t_state r_state, n_state;
    logic [3:0] r_circles;
    logic [2:0] r_idx, n_idx;
    logic [2:0] r_end, n_end;
    logic r_skip, n_skip;
    logic r_query, n_query;
    logic signed [15:0] r_px, r_py;

    logic in_acc, load_we, adv, done;
    logic [3:0] exam;
    t_token token;
    t_entry wdata, rdata;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;

    // Entries examined: saturate the register to the table size and to eight.
    assign exam = (r_circles > 4'(LIMIT)) ? 4'(LIMIT) : r_circles;

    // Drop loads aimed past the end of the table.
    assign load_we = in_acc && (i_action == ACT_LOAD) && (32'(i_slot) < MAX_CIRCLES);
    assign wdata   = '{cx: i_pos_x, cy: i_pos_y, rad: i_radius, cap: i_capacity};

    // Issue one read per cycle while scanning and the scan pipeline advances.
    always_comb begin
        token.vld  = (r_state == ST_SCAN);
        token.idx  = r_idx;
        token.fin  = (r_idx == r_end);
        token.skip = r_skip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circles <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_circles <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_end   <= '0;
            r_skip  <= 1'b0;
            r_query <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_end   <= n_end;
            r_skip  <= n_skip;
            r_query <= n_query;
        end
    end

    // Latch the point with the request.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_end   = r_end;
        n_skip  = r_skip;
        n_query = r_query;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx = '0;
                    case (i_action)
                        ACT_QUERY: begin
                            // An empty table still walks one token to emit "none".
                            n_state = ST_SCAN;
                            n_query = 1'b1;
                            n_skip  = (exam == 4'd0);
                            n_end   = (exam == 4'd0) ? 3'd0 : 3'(exam - 4'd1);
                        end
                        ACT_LARGEST: begin
                            // Entry 0 is always examined as the starting best.
                            n_state = ST_SCAN;
                            n_query = 1'b0;
                            n_skip  = 1'b0;
                            n_end   = (exam == 4'd0) ? 3'd0 : 3'(exam - 4'd1);
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (adv) begin
                    n_idx = r_idx + 3'd1;
                    if (token.fin) begin
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    ccq_table #(
        .DEPTH (MAX_CIRCLES),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (AW'(i_slot)),
        .i_wdata (wdata),
        .i_re    (adv),
        .i_raddr (AW'(r_idx)),
        .o_rdata (rdata)
    );

    ccq_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_token        (token),
        .i_rdata        (rdata),
        .i_px           (r_px),
        .i_py           (r_py),
        .i_query        (r_query),
        .o_adv          (adv),
        .o_done         (done),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_index        (o_index),
        .o_center_x     (o_center_x),
        .o_center_y     (o_center_y),
        .o_radius_out   (o_radius_out),
        .o_capacity_out (o_capacity_out),
        .o_last         (o_last)
    );

endmodule

### hdl/ccq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccq_checker: port-level checks for the circle coverage query unit
// Watches the top-level ports; attached by the bind at the end of the file.
// ----------------------------------------------------------------------------
module ccq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [1:0]         i_action,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_kind,
    input logic [2:0]         o_index,
    input logic signed [15:0] o_center_x,
    input logic [23:0]        o_radius_out,
    input logic               o_last
);
    import ccq_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A "none" result (the only result of its query) carries last and a zero index, center x and radius.
    a_none_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_NONE) |->
            o_last && (o_index == 3'd0) && (o_center_x == 16'sd0) && (o_radius_out == 24'd0))
        else $error("none result with nonzero fields or without last");

    // A largest report is always the final result.
    a_largest_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_LARGEST) |-> o_last)
        else $error("largest report without last");

    // A query holds off the next request while it scans.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_action == ACT_QUERY) |=> o_in_stall)
        else $error("request accepted during a scan");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind circle_coverage_query_unit ccq_checker u_ccq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_action     (i_action),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_kind       (o_kind),
    .o_index      (o_index),
    .o_center_x   (o_center_x),
    .o_radius_out (o_radius_out),
    .o_last       (o_last)
);

### tb/sv/circle_coverage_query_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_coverage_query_unit_test: regression for the circle coverage query unit
// Sends load, query, largest-radius and reserved-code requests with random idling on both
// channels. A table model computes each result, and the results are checked
// field by field, in order.
// ----------------------------------------------------------------------------
module circle_coverage_query_unit_test;
    import ccq_pkg::*;

    localparam int         TABLE_DEPTH   = 8;
    localparam logic [1:0] ACT_RESERVED  = 2'd3;   // dropped by the block
    localparam int         SETTLE_CYCLES = 20;     // covers a full scan of the table
    localparam int         HOLD_CYCLES   = 300;
    localparam int         REPORT_LIMIT  = 10;

    // One result as the block should present it.
    typedef struct {
        t_kind              kind;
        logic [2:0]         index;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [23:0]        rad;
        logic [15:0]        cap;
        logic               last;
    } t_coverage_result;

    // ------------------------------------------------------------------------
    // Block ports; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_action       = ACT_LOAD;
    logic [2:0]         i_slot         = '0;
    logic signed [15:0] i_pos_x        = '0;
    logic signed [15:0] i_pos_y        = '0;
    logic [23:0]        i_radius       = '0;
    logic [15:0]        i_capacity     = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    t_kind              o_kind;
    logic [2:0]         o_index;
    logic signed [15:0] o_center_x;
    logic signed [15:0] o_center_y;
    logic [23:0]        o_radius_out;
    logic [15:0]        o_capacity_out;
    logic               o_last;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_data     = '0;

    // ------------------------------------------------------------------------
    // Shadow table, circle count and the queue of pending results.
    // ------------------------------------------------------------------------
    t_entry             circle_table [TABLE_DEPTH];
    logic [3:0]         circle_count = '0;
    t_coverage_result   pending_results [$];

    int                 error_count    = 0;
    int                 hold_ticket    = 0;   // bumped to ask for a long hold-off
    int                 hold_served    = 0;
    int                 hold_left      = 0;
    int                 stall_left     = 0;
    bit                 quiet_traffic  = 1'b0; // no idling on either side

    circle_coverage_query_unit #(
        .MAX_CIRCLES(TABLE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_slot        (i_slot),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_radius      (i_radius),
        .i_capacity    (i_capacity),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_index       (o_index),
        .o_center_x    (o_center_x),
        .o_center_y    (o_center_y),
        .o_radius_out  (o_radius_out),
        .o_capacity_out(o_capacity_out),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Result prediction
    // ------------------------------------------------------------------------
    // Build one result from a table entry; a "none" result carries zeros.
    function automatic t_coverage_result make_result(t_kind kind, int unsigned e, bit last);
        t_coverage_result r;
        r.kind = kind;
        r.last = last;
        if (kind == KIND_NONE) begin
            r.index = '0;
            r.cx    = '0;
            r.cy    = '0;
            r.rad   = '0;
            r.cap   = '0;
        end else begin
            r.index = e[2:0];
            r.cx    = circle_table[e].cx;
            r.cy    = circle_table[e].cy;
            r.rad   = circle_table[e].rad;
            r.cap   = circle_table[e].cap;
        end
        return r;
    endfunction

    // Apply one accepted request to the shadow table and queue its results.
    function automatic void predict_request(logic [1:0] act, logic [2:0] slot,
                                            logic signed [15:0] px, logic signed [15:0] py,
                                            logic [23:0] rad, logic [15:0] cap);
        int unsigned scan;
        int unsigned best;
        logic [23:0] best_rad;
        logic [7:0]  covered;
        longint      dx;
        longint      dy;
        longint      dist2;
        longint      rad2;
        // Saturate the count at the table depth.
        scan = (circle_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(circle_count);
        case (act)
            ACT_LOAD: begin
                circle_table[slot].cx  = px;
                circle_table[slot].cy  = py;
                circle_table[slot].rad = rad;
                circle_table[slot].cap = cap;
            end
            ACT_QUERY: begin
                covered = '0;
                for (int e = 0; e < scan; e++) begin
                    dx    = longint'(px) - longint'($signed(circle_table[e].cx));
                    dy    = longint'(py) - longint'($signed(circle_table[e].cy));
                    // Scale the distance by 2^16 to match 8 fraction bits of radius.
                    dist2 = (dx * dx + dy * dy) << 16;
                    rad2  = longint'(circle_table[e].rad) * longint'(circle_table[e].rad);
                    covered[e] = (dist2 <= rad2);
                end
                if (covered == '0) begin
                    pending_results.push_back(make_result(KIND_NONE, 0, 1'b1));
                end else begin
                    for (int e = 0; e < TABLE_DEPTH; e++) begin
                        if (covered[e]) begin
                            pending_results.push_back(
                                make_result(KIND_HIT, e, (covered >> (e + 1)) == '0));
                        end
                    end
                end
            end
            ACT_LARGEST: begin
                // Start from entry 0; only a strictly greater radius wins.
                best     = 0;
                best_rad = circle_table[0].rad;
                for (int e = 0; e < scan; e++) begin
                    if (circle_table[e].rad > best_rad) begin
                        best     = e;
                        best_rad = circle_table[e].rad;
                    end
                end
                pending_results.push_back(make_result(KIND_LARGEST, best, 1'b1));
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result receiver: random stall bursts, plus a long hold-off on request.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet_traffic && $urandom_range(0, 5) == 0) begin
            // Start a stall burst; stall_left sets its random length.
            stall_left  <= $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest pending one.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_coverage_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("%0t: result with nothing pending: kind %0d index %0d last %b",
                             $realtime, o_kind, o_index, o_last);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind || o_index !== want.index
                        || o_center_x !== want.cx || o_center_y !== want.cy
                        || o_radius_out !== want.rad || o_capacity_out !== want.cap
                        || o_last !== want.last) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: expected kind %0d idx %0d c (%0d,%0d) r %h cap %h last %b",
                                 $realtime, want.kind, want.index, want.cx, want.cy,
                                 want.rad, want.cap, want.last);
                        $display("%0t:      got kind %0d idx %0d c (%0d,%0d) r %h cap %h last %b",
                                 $realtime, o_kind, o_index, o_center_x, o_center_y,
                                 o_radius_out, o_capacity_out, o_last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offer one request, hold it until accepted, predict it, then maybe idle.
    task automatic send_request(logic [1:0] act, logic [2:0] slot,
                                logic signed [15:0] px, logic signed [15:0] py,
                                logic [23:0] rad, logic [15:0] cap);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_slot     <= slot;
        i_pos_x    <= px;
        i_pos_y    <= py;
        i_radius   <= rad;
        i_capacity <= cap;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(act, slot, px, py, rad, cap);
        // Drop valid for a random burst now and then.
        if (!quiet_traffic && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Pause the request side until every pending result has arrived.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // A trailing load may still be in flight; let it settle.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write circles_in_use; only ever done with the block idle.
    task automatic write_circle_count(logic [3:0] count);
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        circle_count  = count;
    endtask

    // One random request; reserved codes do not count as items.
    task automatic random_request(output bit counted);
        int unsigned        pick;
        int                 e;
        int                 lim;
        int                 ox;
        int                 oy;
        logic [2:0]         slot;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [23:0]        rad;
        logic [15:0]        cap;
        pick    = $urandom_range(0, 99);
        slot    = 3'($urandom_range(0, 7));
        px      = 16'($urandom);
        py      = 16'($urandom);
        cap     = 16'($urandom);
        rad     = $urandom_range(0, 1) ? 24'($urandom_range(0, 24'hFFFFFF))
                                       : 24'($urandom_range(0, 24'h00FFFF));
        counted = 1'b1;
        if (pick < 30) begin
            send_request(ACT_LOAD, slot, px, py, rad, cap);
        end else if (pick < 75) begin
            if (pick < 66) begin
                // Aim near a stored center, within about its radius.
                e   = $urandom_range(0, TABLE_DEPTH - 1);
                lim = int'(circle_table[e].rad >> 8);
                if (lim > 32767) lim = 32767;
                ox  = int'($urandom_range(0, 2 * lim)) - lim;
                oy  = int'($urandom_range(0, 2 * lim)) - lim;
                px  = 16'(int'(circle_table[e].cx) + ox);
                py  = 16'(int'(circle_table[e].cy) + oy);
            end
            send_request(ACT_QUERY, slot, px, py, rad, cap);
        end else if (pick < 90) begin
            send_request(ACT_LARGEST, slot, px, py, rad, cap);
        end else begin
            send_request(ACT_RESERVED, slot, px, py, rad, cap);
            counted = 1'b0;
        end
    endtask

    task automatic run_random_items(int items);
        int sent;
        bit counted;
        sent = 0;
        while (sent < items) begin
            random_request(counted);
            if (counted) sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Count is 0 after reset: a query gives one "none"; code 3 is dropped.
    task automatic test_empty_table();
        send_request(ACT_QUERY, 3'd0, 16'sd0, 16'sd0, 24'd0, 16'd0);
        send_request(ACT_RESERVED, 3'd7, -16'sd1, -16'sd1, 24'hFFFFFF, 16'hFFFF);
    endtask

    // Fill every entry with extreme and boundary circles.
    task automatic test_load_table();
        send_request(ACT_LOAD, 3'd0, 16'sd0, 16'sd0, 24'd1280, 16'h0001);
        send_request(ACT_LOAD, 3'd1, -16'sd32768, -16'sd32768, 24'hFFFFFF, 16'hFFFF);
        send_request(ACT_LOAD, 3'd2, 16'sd32767, 16'sd32767, 24'hFFFFFF, 16'h8000);
        send_request(ACT_LOAD, 3'd3, 16'sd0, 16'sd0, 24'd0, 16'h0000);
        send_request(ACT_LOAD, 3'd4, 16'sd100, -16'sd100, 24'd1281, 16'h1234);
        send_request(ACT_LOAD, 3'd5, 16'sd0, 16'sd0, 24'hFFFFFF, 16'h5555);
        send_request(ACT_LOAD, 3'd6, -16'sd1, -16'sd1, 24'd255, 16'hAAAA);
        send_request(ACT_LOAD, 3'd7, 16'sd32767, -16'sd32768, 24'd256, 16'h7FFF);
    endtask

    // Full table: multiple hits, points on and just past a boundary, far corners.
    task automatic test_coverage_points();
        write_circle_count(4'd8);
        send_request(ACT_QUERY, 3'd0, 16'sd0, 16'sd0, 24'd0, 16'd0);
        send_request(ACT_QUERY, 3'd5, 16'sd3, 16'sd4, 24'hFFFFFF, 16'hFFFF);
        send_request(ACT_QUERY, 3'd2, 16'sd3, 16'sd5, 24'd0, 16'd0);
        send_request(ACT_QUERY, 3'd0, -16'sd32768, 16'sd32767, 24'd0, 16'd0);
        send_request(ACT_QUERY, 3'd1, 16'sd32767, -16'sd32768, 24'd0, 16'd0);
        send_request(ACT_QUERY, 3'd0, -16'sd1, -16'sd1, 24'd0, 16'd0);
    endtask

    // Three entries share the maximum radius; the first must win.
    task automatic test_largest_ties();
        send_request(ACT_LARGEST, 3'd0, 16'sd0, 16'sd0, 24'd0, 16'd0);
    endtask

    // Count at one, zero and above the table depth.
    task automatic test_count_extremes();
        write_circle_count(4'd1);
        send_request(ACT_QUERY, 3'd0, 16'sd1000, 16'sd1000, 24'd0, 16'd0);
        send_request(ACT_LARGEST, 3'd0, 16'sd0, 16'sd0, 24'd0, 16'd0);
        write_circle_count(4'd0);
        send_request(ACT_LARGEST, 3'd0, 16'sd0, 16'sd0, 24'd0, 16'd0);
        send_request(ACT_QUERY, 3'd0, 16'sd0, 16'sd0, 24'd0, 16'd0);
        write_circle_count(4'd15);
        send_request(ACT_LARGEST, 3'd0, 16'sd0, 16'sd0, 24'd0, 16'd0);
        send_request(ACT_QUERY, 3'd0, 16'sd0, 16'sd0, 24'd0, 16'd0);
        write_circle_count(4'd9);
        send_request(ACT_QUERY, 3'd0, -16'sd1, -16'sd1, 24'd0, 16'd0);
    endtask

    // Random traffic in phases, reconfiguring the count between them.
    task automatic test_random_phases();
        logic [3:0] counts [6];
        counts = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd0};
        counts[5] = 4'($urandom_range(0, 15));
        for (int p = 0; p < 6; p++) begin
            write_circle_count(counts[p]);
            run_random_items(30);
        end
    endtask

    // Hold results off for a long stretch while queries keep coming, so the
    // block fills up and stalls its request side.
    task automatic test_backpressure();
        write_circle_count(4'd8);
        for (int e = 0; e < TABLE_DEPTH; e++) begin
            send_request(ACT_LOAD, e[2:0], 16'(int'($urandom_range(0, 2000)) - 1000),
                         16'(int'($urandom_range(0, 2000)) - 1000),
                         24'($urandom_range(512000, 1024000)), 16'($urandom));
        end
        hold_ticket <= hold_ticket + 1;
        for (int q = 0; q < 16; q++) begin
            send_request(ACT_QUERY, 3'd0, 16'(int'($urandom_range(0, 1000)) - 500),
                         16'(int'($urandom_range(0, 1000)) - 500), 24'd0, 16'd0);
        end
        wait_results_drained();
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_streaming();
        quiet_traffic <= 1'b1;
        write_circle_count(4'd8);
        run_random_items(30);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_load_table();
        test_coverage_points();
        test_largest_ties();
        test_count_extremes();
        test_random_phases();
        test_backpressure();
        test_streaming();

        // Drain, then give the block a few cycles to show any stray result.
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("circle_coverage_query_unit regression: pass");
        end else begin
            $display("circle_coverage_query_unit regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("circle_coverage_query_unit regression: fail");
        $finish;
    end

endmodule
